// ===== sv/mjcd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mjcd_pkg
// Types, codes and decode helpers for the MPSSE JTAG command decoder.
// ----------------------------------------------------------------------------
package mjcd_pkg;

  localparam logic [1:0] ACT_SHIFT = 2'd0;
  localparam logic [1:0] ACT_REPLY = 2'd1;
  localparam logic [1:0] ACT_PINS  = 2'd2;
  localparam logic [1:0] ACT_FLUSH = 2'd3;

  localparam logic [7:0] BAD_CMD_REPLY = 8'hfa;
  localparam logic [7:0] OP_SET_LOW    = 8'h80;
  localparam logic [7:0] OP_GET_LOW    = 8'h81;
  localparam logic [7:0] OP_SET_HIGH   = 8'h82;
  localparam logic [7:0] OP_GET_HIGH   = 8'h83;
  localparam logic [7:0] OP_LOOP_ON    = 8'h84;
  localparam logic [7:0] OP_LOOP_OFF   = 8'h85;
  localparam logic [7:0] OP_CLK_DIV    = 8'h86;
  localparam logic [7:0] OP_FLUSH      = 8'h87;
  localparam logic [7:0] OP_CLK_8A     = 8'h8a;
  localparam logic [7:0] OP_CLK_8B     = 8'h8b;
  localparam logic [7:0] OP_CLK_8D     = 8'h8d;
  localparam logic [7:0] OP_CLK_97     = 8'h97;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  out_byte;
    logic [3:0]  bit_count;
    logic [16:0] repeat_count;
    logic        drive_tdi;
    logic        capture_tdo;
    logic        on_tms;
    logic        tdi_level;
    logic [7:0]  pin_dir;
    logic        last;
  } result_t;

  typedef struct packed {
    result_t res0;
    result_t res1;
    logic    two;
  } entry_t;

  function automatic logic [7:0] rev8(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = b[7-i];
    end
    return r;
  endfunction

  function automatic result_t blank_res();
    result_t r;
    r              = '0;
    r.bit_count    = 4'd8;
    r.repeat_count = 17'd1;
    return r;
  endfunction

  function automatic result_t reply_res(input logic [7:0] b);
    result_t r;
    r          = blank_res();
    r.action   = ACT_REPLY;
    r.out_byte = b;
    return r;
  endfunction

  function automatic logic [2:0] cmd_len(input logic [7:0] c);
    logic [2:0] l;
    if (c[7]) begin
      if (c == 8'h90 || c == 8'h8e) begin
        l = 3'd2;
      end else if (c == OP_SET_LOW || c == OP_SET_HIGH || c == OP_CLK_DIV ||
                   c == 8'h91 || c == 8'h92 || c == 8'h8f || c == 8'h9c ||
                   c == 8'h9d || c == 8'h9e) begin
        l = 3'd3;
      end else if (c == 8'h93) begin
        l = 3'd4;
      end else begin
        l = 3'd1;
      end
    end else if (c[1]) begin
      l = ((c & 8'h50) != 8'h00) ? 3'd3 : 3'd2;
    end else begin
      l = 3'd3;
    end
    return l;
  endfunction

  function automatic logic shift_valid(input logic [7:0] c);
    logic v;
    case (c)
      8'h10, 8'h11, 8'h12, 8'h13, 8'h18, 8'h19, 8'h1a, 8'h1b,
      8'h20, 8'h22, 8'h24, 8'h26, 8'h28, 8'h2a, 8'h2c, 8'h2e,
      8'h31, 8'h33, 8'h34, 8'h36, 8'h39, 8'h3b, 8'h3c, 8'h3e,
      8'h4a, 8'h4b, 8'h6a, 8'h6b, 8'h6e, 8'h6f: v = 1'b1;
      default: v = 1'b0;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/mjcd_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mjcd_in_if
// Input channel: host or TDO byte with valid/ready.
// ----------------------------------------------------------------------------
interface mjcd_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink (input valid, input op, input data_byte, output ready);
endinterface

// ===== sv/mjcd_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mjcd_out_if
// Output channel: decoded actions with valid/ready.
// ----------------------------------------------------------------------------
interface mjcd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  out_byte;
  logic [3:0]  bit_count;
  logic [16:0] repeat_count;
  logic        drive_tdi;
  logic        capture_tdo;
  logic        on_tms;
  logic        tdi_level;
  logic [7:0]  pin_dir;
  logic        last;

  modport source (output valid, output action, output out_byte, output bit_count,
                  output repeat_count, output drive_tdi, output capture_tdo,
                  output on_tms, output tdi_level, output pin_dir, output last,
                  input ready);
  modport sink (input valid, input action, input out_byte, input bit_count,
                input repeat_count, input drive_tdi, input capture_tdo,
                input on_tms, input tdi_level, input pin_dir, input last,
                output ready);
endinterface

// ===== sv/mjcd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mjcd_front
// Command assembly and decode; emits one queue entry per productive transfer.
// ----------------------------------------------------------------------------
module mjcd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            in_op_i,
  input  logic [7:0]      in_byte_i,
  output logic            push_valid_o,
  input  logic            push_ready_i,
  output mjcd_pkg::entry_t push_data_o
);
  import mjcd_pkg::*;

  logic        en_q;
  logic [7:0]  opcode_q, opcode_d;
  logic [7:0]  arg_q [3];
  logic [7:0]  arg_d [3];
  logic [2:0]  held_q, held_d, held_n;
  logic [16:0] pl_q, pl_d;
  logic [7:0]  pop_q, pop_d;
  logic        loop_q, loop_d;
  logic        trev_q, trev_d;
  logic [1:0]  n;
  result_t     r0, r1;
  logic [7:0]  b, c, data;
  logic [2:0]  bits;
  logic [16:0] len;
  logic        accept;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i & push_ready_i;
  assign b          = in_byte_i;

  always_comb begin
    opcode_d = opcode_q;
    arg_d    = arg_q;
    held_d   = held_q;
    held_n   = held_q;
    pl_d     = pl_q;
    pop_d    = pop_q;
    loop_d   = loop_q;
    trev_d   = trev_q;
    n        = 2'd0;
    r0       = blank_res();
    r1       = blank_res();
    c        = opcode_q;
    data     = 8'h00;
    bits     = 3'd0;
    len      = 17'd0;
    if (in_op_i) begin
      r0 = reply_res(trev_q ? rev8(b) : b);
      n  = 2'd1;
    end else if (en_q) begin
      if (pl_q != 17'd0) begin
        pl_d = pl_q - 17'd1;
        n    = 2'd1;
        if (loop_q) begin
          r0 = reply_res(b);
        end else begin
          r0.action      = ACT_SHIFT;
          r0.out_byte    = pop_q[3] ? b : rev8(b);
          r0.drive_tdi   = 1'b1;
          r0.capture_tdo = pop_q[5];
        end
      end else begin
        if (held_q == 3'd0) begin
          opcode_d = b;
          held_n   = 3'd1;
        end else begin
          arg_d[held_q[1:0] - 2'd1] = b;
          held_n = held_q + 3'd1;
        end
        c = opcode_d;
        if (held_n < cmd_len(c)) begin
          held_d = held_n;
        end else begin
          held_d = 3'd0;
          if (c[7]) begin
            if (c == OP_SET_LOW) begin
              r0.action   = ACT_PINS;
              r0.out_byte = arg_d[0];
              r0.pin_dir  = arg_d[1];
              n = 2'd1;
            end else if (c == OP_SET_HIGH || c == OP_CLK_DIV || c == OP_CLK_8A ||
                         c == OP_CLK_8B || c == OP_CLK_8D || c == OP_CLK_97) begin
              n = 2'd0;
            end else if (c == OP_GET_LOW || c == OP_GET_HIGH) begin
              r0 = reply_res(8'h00);
              n  = 2'd1;
            end else if (c == OP_LOOP_ON) begin
              loop_d = 1'b1;
            end else if (c == OP_LOOP_OFF) begin
              loop_d = 1'b0;
            end else if (c == OP_FLUSH) begin
              r0.action = ACT_FLUSH;
              n = 2'd1;
            end else begin
              r0 = reply_res(BAD_CMD_REPLY);
              r1 = reply_res(c);
              n  = 2'd2;
            end
          end else if (!shift_valid(c)) begin
            r0 = reply_res(BAD_CMD_REPLY);
            n  = 2'd1;
          end else if (c[1]) begin
            bits = arg_d[0][2:0];
            data = ((c & 8'h50) != 8'h00) ? arg_d[1] : 8'h00;
            if (c[5]) begin
              trev_d = ~c[3];
            end
            r0.action      = ACT_SHIFT;
            r0.bit_count   = {1'b0, bits} + 4'd1;
            r0.capture_tdo = c[5];
            n = 2'd1;
            if (c[6]) begin
              r0.out_byte  = data;
              r0.on_tms    = 1'b1;
              r0.tdi_level = data[7];
            end else begin
              r0.drive_tdi = c[4];
              r0.out_byte  = c[4] ? (c[3] ? data : rev8(data)) : 8'h00;
            end
          end else begin
            len = {1'b0, arg_d[1], arg_d[0]} + 17'd1;
            if (c[5]) begin
              trev_d = ~c[3];
            end
            if (c[4]) begin
              pl_d  = len;
              pop_d = c;
            end else begin
              r0.action       = ACT_SHIFT;
              r0.repeat_count = len;
              r0.capture_tdo  = 1'b1;
              n = 2'd1;
            end
          end
        end
      end
    end
    r0.last = (n == 2'd1);
    r1.last = 1'b1;
  end

  assign push_valid_o     = in_valid_i & (n != 2'd0);
  assign push_data_o.res0 = r0;
  assign push_data_o.res1 = r1;
  assign push_data_o.two  = (n == 2'd2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q     <= 1'b0;
      opcode_q <= 8'h00;
      arg_q    <= '{default: 8'h00};
      held_q   <= 3'd0;
      pl_q     <= 17'd0;
      pop_q    <= 8'h00;
      loop_q   <= 1'b0;
      trev_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        en_q <= cfg_wdata_i;
      end
      if (accept) begin
        opcode_q <= opcode_d;
        arg_q    <= arg_d;
        held_q   <= held_d;
        pl_q     <= pl_d;
        pop_q    <= pop_d;
        loop_q   <= loop_d;
        trev_q   <= trev_d;
      end
    end
  end

endmodule

// ===== sv/mjcd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mjcd_queue
// Two-entry queue between decode and issue.
// ----------------------------------------------------------------------------
module mjcd_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  mjcd_pkg::entry_t push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output mjcd_pkg::entry_t pop_data_o
);
  import mjcd_pkg::*;

  entry_t     mem [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = mem[rd_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_ready_i & pop_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> (wr_q == rd_q)) else $error("pointer mismatch");
  a_ptr_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1) |-> (wr_q != rd_q)) else $error("pointer mismatch at one");
`endif

endmodule

// ===== sv/mjcd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mjcd_back
// Issues queued entries one result per transfer from a holding register.
// ----------------------------------------------------------------------------
module mjcd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pop_valid_i,
  output logic             pop_ready_o,
  input  mjcd_pkg::entry_t pop_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output mjcd_pkg::result_t out_res_o
);
  import mjcd_pkg::*;

  entry_t cur_q;
  logic   cur_valid_q, phase_q;
  logic   fire, done, load;

  assign out_valid_o = cur_valid_q;
  assign out_res_o   = phase_q ? cur_q.res1 : cur_q.res0;
  assign fire        = cur_valid_q & out_ready_i;
  assign done        = fire & (~cur_q.two | phase_q);
  assign load        = ~cur_valid_q | done;
  assign pop_ready_o = load;

  always_ff @(posedge clk_i) begin
    if (load && pop_valid_i) begin
      cur_q <= pop_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else if (load) begin
      cur_valid_q <= pop_valid_i;
      phase_q     <= 1'b0;
    end else if (fire) begin
      phase_q <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_phase_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> (cur_valid_q && cur_q.two)) else $error("second phase without pair");
  a_last_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> out_res_o.last) else $error("entry ends without last");
  a_pair_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_valid_q && cur_q.two && !phase_q) |-> !out_res_o.last)
    else $error("last on first of pair");
`endif

endmodule

// ===== sv/mpsse_jtag_command_decoder_core.sv =====
`timescale 1ns / 1ps
// A two-entry queue decouples decode from issue: an input transfer passes
// through the queue, then the issue holding register. Throughput: one input
// per cycle while the queue has room; one result per cycle while the output
// is ready; an input producing a bad-command pair issues both results in turn.
// Reset (rst_ni low, async) clears all command state, loopback and enable.
// ----------------------------------------------------------------------------
// mpsse_jtag_command_decoder_core
// MPSSE command stream decoder producing shift, reply, pin and flush actions.
// ----------------------------------------------------------------------------
module mpsse_jtag_command_decoder_core (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  mjcd_in_if.sink   in_i,
  mjcd_out_if.source out_o
);
  import mjcd_pkg::*;

  logic    push_valid, push_ready, pop_valid, pop_ready;
  entry_t  push_data, pop_data;
  result_t res;

  mjcd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .in_op_i      (in_i.op),
    .in_byte_i    (in_i.data_byte),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  mjcd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  mjcd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_res_o   (res)
  );

  assign out_o.action       = res.action;
  assign out_o.out_byte     = res.out_byte;
  assign out_o.bit_count    = res.bit_count;
  assign out_o.repeat_count = res.repeat_count;
  assign out_o.drive_tdi    = res.drive_tdi;
  assign out_o.capture_tdo  = res.capture_tdo;
  assign out_o.on_tms       = res.on_tms;
  assign out_o.tdi_level    = res.tdi_level;
  assign out_o.pin_dir      = res.pin_dir;
  assign out_o.last         = res.last;

endmodule
